@@ rtl/core/bmcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect package
// Shared widths, constants, register indexes and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package bmcd_pkg;

    // Fixed field widths
    localparam int PACK_BITS     = 12;
    localparam int CELL_BITS     = 4;
    localparam int EMPTY_BITS    = 9;
    localparam int THR_BITS      = 13;
    localparam int ELAPSED_BITS  = 20;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIMER_BITS_DEF  = 21;

    // Configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_CELL  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_COUNT = CFG_IDX_BITS'(1);
    localparam logic [EMPTY_BITS-1:0]   EMPTY_RESET     = EMPTY_BITS'(350);

    // Voltage and timing constants (centivolts, microseconds)
    localparam int FULL_SCALE_CV  = 3630;
    localparam int ATTACH_MIN_CV  = 250;
    localparam int DETACH_MAX_CV  = 150;
    localparam int CELL_OFFSET_CV = 11;
    localparam int CELL_SPAN_CV   = 435;
    localparam int ALARM_FLOOR_CV = 50;
    localparam int ATTACH_HOLD_US = 1000000;
    localparam int DETACH_HOLD_US = 500000;

    // Largest possible (pack - offset) / span over the full-scale range
    localparam int CELL_STEPS = (FULL_SCALE_CV - 1 - CELL_OFFSET_CV) / CELL_SPAN_CV;

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS    = PACK_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef struct packed {
        logic capture;
        logic scale;
        logic decide;
        logic thresh;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/bmcd_if.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect channel interfaces
// Sample input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface bmcd_in_if #(
    parameter int SAMPLE_BITS = bmcd_pkg::SAMPLE_BITS_DEF
);
    import bmcd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SAMPLE_BITS-1:0]  raw_sample;
    logic [ELAPSED_BITS-1:0] elapsed_us;

    modport source (output valid, output raw_sample, output elapsed_us, input ready);
    modport sink   (input valid, input raw_sample, input elapsed_us, output ready);
endinterface

interface bmcd_out_if;
    import bmcd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PACK_BITS-1:0] pack_centivolts;
    logic [PACK_BITS-1:0] cell_centivolts;
    logic [CELL_BITS-1:0] cells_in_use;
    logic                 pack_present;
    logic                 alarm_active;
    logic                 alarm_started;
    logic                 alarm_stopped;

    modport source (output valid, output pack_centivolts, output cell_centivolts,
                    output cells_in_use, output pack_present, output alarm_active,
                    output alarm_started, output alarm_stopped, input ready);
    modport sink   (input valid, input pack_centivolts, input cell_centivolts,
                    input cells_in_use, input pack_present, input alarm_active,
                    input alarm_started, input alarm_stopped, output ready);
endinterface

interface bmcd_cfg_if;
    import bmcd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/bmcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect controller
// Sequences one sample word through scale, decision, threshold, divide and
// output load.
// ----------------------------------------------------------------------------
module bmcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bmcd_pkg::t_dp_sts i_sts,
    output bmcd_pkg::t_dp_cmd o_cmd
);
    import bmcd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_THRESH = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_THRESH;
            end
            S_THRESH: begin
                o_cmd.thresh = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold the finished word until the output register can take it.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/bmcd_dp.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect datapath
// Scaling multiplier, hold timer, attach/detach state, threshold multiplier,
// serial cell divider, alarm logic, configuration and output registers.
// ----------------------------------------------------------------------------
module bmcd_dp #(
    parameter int SAMPLE_BITS = bmcd_pkg::SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = bmcd_pkg::TIMER_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bmcd_pkg::t_dp_cmd                  i_cmd,
    output bmcd_pkg::t_dp_sts                  o_sts,
    input  logic [SAMPLE_BITS-1:0]             i_raw_sample,
    input  logic [bmcd_pkg::ELAPSED_BITS-1:0]  i_elapsed_us,
    input  logic                               i_cfg_valid,
    input  logic [bmcd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bmcd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [bmcd_pkg::PACK_BITS-1:0]     o_pack_centivolts,
    output logic [bmcd_pkg::PACK_BITS-1:0]     o_cell_centivolts,
    output logic [bmcd_pkg::CELL_BITS-1:0]     o_cells_in_use,
    output logic                               o_pack_present,
    output logic                               o_alarm_active,
    output logic                               o_alarm_started,
    output logic                               o_alarm_stopped
);
    import bmcd_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + PACK_BITS;

    // Configuration
    logic [EMPTY_BITS-1:0] r_empty_cell;
    logic [CELL_BITS-1:0]  r_fixed_count;

    // Captured word and scaled values
    logic [SAMPLE_BITS-1:0]  r_raw;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [PACK_BITS-1:0]    r_pack;
    logic [TIMER_BITS-1:0]   r_tsum;
    logic                    r_attach;

    // Persistent monitor state
    logic                  r_mode;
    logic [TIMER_BITS-1:0] r_timer;
    logic [CELL_BITS-1:0]  r_detected;
    logic [THR_BITS-1:0]   r_thr;
    logic                  r_alarm;

    // Divider
    logic [CELL_BITS-1:0]    r_divisor;
    logic [PACK_BITS-1:0]    r_quot;
    logic [CELL_BITS-1:0]    r_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt;

    logic r_out_valid;

    logic [PROD_BITS-1:0]  w_prod;
    logic [TIMER_BITS:0]   w_tsum_wide;
    logic [TIMER_BITS-1:0] w_tsat;
    logic [CELL_BITS-1:0]  w_step_cnt;
    logic [CELL_BITS-1:0]  w_det_new;
    logic [CELL_BITS-1:0]  w_cells;
    logic [THR_BITS-1:0]   w_thr_prod;
    logic [CELL_BITS:0]    w_rem_sh;
    logic                  w_qbit;
    logic [THR_BITS-1:0]   w_pack_ext;
    logic                  w_stop;
    logic                  w_start;
    logic                  w_alarm_next;

    assign w_prod      = PROD_BITS'(r_raw) * PROD_BITS'(FULL_SCALE_CV);
    assign w_tsum_wide = {1'b0, r_timer} + (TIMER_BITS + 1)'(r_elapsed);
    assign w_tsat      = w_tsum_wide[TIMER_BITS] ? '1 : w_tsum_wide[TIMER_BITS-1:0];

    // Cell count from the attach voltage: count of span boundaries passed.
    always_comb begin
        w_step_cnt = '0;
        for (int k = 1; k <= CELL_STEPS; k++) begin
            if (r_pack >= PACK_BITS'(CELL_OFFSET_CV + k * CELL_SPAN_CV)) begin
                w_step_cnt = w_step_cnt + CELL_BITS'(1);
            end
        end
    end

    assign w_det_new  = w_step_cnt + CELL_BITS'(1);
    assign w_cells    = (r_fixed_count != '0) ? r_fixed_count : r_detected;
    assign w_thr_prod = THR_BITS'(w_cells) * THR_BITS'(r_empty_cell);

    assign w_rem_sh = {r_rem, r_quot[PACK_BITS-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_divisor});

    assign w_pack_ext   = THR_BITS'(r_pack);
    assign w_stop       = r_alarm && ((w_pack_ext >= r_thr) ||
                                      (r_pack < PACK_BITS'(ALARM_FLOOR_CV)));
    assign w_start      = !r_alarm && (w_pack_ext < r_thr);
    assign w_alarm_next = w_stop ? 1'b0 : (w_start ? 1'b1 : r_alarm);

    assign o_sts.div_last = (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    // Control and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_cell  <= EMPTY_RESET;
            r_fixed_count <= '0;
            r_mode        <= 1'b0;
            r_timer       <= '0;
            r_detected    <= CELL_BITS'(1);
            r_thr         <= '0;
            r_alarm       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_EMPTY_CELL:  r_empty_cell  <= i_cfg_data[EMPTY_BITS-1:0];
                    REG_FIXED_COUNT: r_fixed_count <= i_cfg_data[CELL_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.decide) begin
                if (!r_mode) begin
                    if (r_pack < PACK_BITS'(ATTACH_MIN_CV)) begin
                        r_timer <= '0;
                    end else begin
                        r_timer <= r_tsum;
                        if (r_tsum > TIMER_BITS'(ATTACH_HOLD_US)) begin
                            if (r_fixed_count == '0) begin
                                r_detected <= w_det_new;
                            end
                            r_mode <= 1'b1;
                        end
                    end
                end else begin
                    if (r_pack > PACK_BITS'(DETACH_MAX_CV)) begin
                        r_timer <= '0;
                    end else begin
                        r_timer <= r_tsum;
                        if (r_tsum > TIMER_BITS'(DETACH_HOLD_US)) begin
                            if (r_fixed_count == '0) begin
                                r_detected <= CELL_BITS'(1);
                            end
                            r_thr  <= '0;
                            r_mode <= 1'b0;
                        end
                    end
                end
            end

            if (i_cmd.thresh && r_attach) begin
                r_thr <= w_thr_prod;
            end

            if (i_cmd.out_load) begin
                r_alarm     <= w_alarm_next;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw     <= i_raw_sample;
            r_elapsed <= i_elapsed_us;
        end
        if (i_cmd.scale) begin
            r_pack <= w_prod[SAMPLE_BITS +: PACK_BITS];
            r_tsum <= w_tsat;
        end
        if (i_cmd.decide) begin
            r_attach <= !r_mode && (r_pack >= PACK_BITS'(ATTACH_MIN_CV)) &&
                        (r_tsum > TIMER_BITS'(ATTACH_HOLD_US));
        end
        if (i_cmd.thresh) begin
            r_divisor <= (w_cells == '0) ? CELL_BITS'(1) : w_cells;
            r_quot    <= r_pack;
            r_rem     <= '0;
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? w_rem_sh[CELL_BITS-1:0] - r_divisor
                             : w_rem_sh[CELL_BITS-1:0];
            r_quot <= {r_quot[PACK_BITS-2:0], w_qbit};
            r_cnt  <= r_cnt + DIV_CNT_BITS'(1);
        end
        if (i_cmd.out_load) begin
            o_pack_centivolts <= r_pack;
            o_cell_centivolts <= r_quot;
            o_cells_in_use    <= w_cells;
            o_pack_present    <= r_mode;
            o_alarm_active    <= w_alarm_next;
            o_alarm_started   <= w_start && !w_stop;
            o_alarm_stopped   <= w_stop;
        end
    end

endmodule

@@ rtl/core/battery_monitor_cell_detect_unit.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect unit
// Scales battery ADC samples to centivolts, tracks pack attach and detach,
// detects the cell count and raises a low-voltage alarm.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries                                   Handshake
//  i_in      in         raw_sample, elapsed_us                    valid/ready
//  o_out     out        pack/cell voltage, cells, present, alarm  valid/ready
//  i_cfg     in         index, data (0: empty cV/cell, 1: cells)  valid/ready
//
//  A word passes from its acceptance through a capture, a scaling multiply,
//  an attach/detach decision, a threshold multiply, twelve steps of the serial
//  divider that splits the pack voltage by the cell count, and an output load.
//  The divider is the longest part; the next word is accepted only after the
//  output load. The result becomes valid in the same cycle as ready rises again.
//  The result sits in an output register, so the next word is accepted while
//  it waits; the output load itself waits only if that register is still full.
//  Reset is synchronous and active low; the configuration port is always ready.
//
module battery_monitor_cell_detect_unit #(
    parameter int SAMPLE_BITS = bmcd_pkg::SAMPLE_BITS_DEF,
    parameter int TIMER_BITS  = bmcd_pkg::TIMER_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bmcd_in_if.sink  i_in,
    bmcd_out_if.source o_out,
    bmcd_cfg_if.sink i_cfg
);
    import bmcd_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // The input channel is ready only while the controller waits for a word.
    assign i_in.ready  = w_in_ready;
    // Configuration writes land directly in their registers.
    assign i_cfg.ready = 1'b1;

    bmcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bmcd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_raw_sample      (i_in.raw_sample),
        .i_elapsed_us      (i_in.elapsed_us),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_pack_centivolts (o_out.pack_centivolts),
        .o_cell_centivolts (o_out.cell_centivolts),
        .o_cells_in_use    (o_out.cells_in_use),
        .o_pack_present    (o_out.pack_present),
        .o_alarm_active    (o_out.alarm_active),
        .o_alarm_started   (o_out.alarm_started),
        .o_alarm_stopped   (o_out.alarm_stopped)
    );

    // A word just accepted keeps the controller busy in the next cycle.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while a word is still in work");

    // The controller never loads over a result that has not been taken.
    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("output register overwritten");

    // The alarm cannot start and stop on the same sample.
    a_alarm_pulses : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.alarm_started && o_out.alarm_stopped))
        else $error("alarm start and stop pulses together");

    // The effective cell count is never zero.
    a_cells_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.cells_in_use != '0))
        else $error("zero cell count reported");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Battery monitor cell detect unit testbench
// Drives ADC sample words into the unit and checks every result word field by
// field against an in-bench prediction of the attach/detach state machine,
// the cell-count detection and the low-voltage alarm. Covers directed corner
// cases, several register settings, random sender gaps and receiver stalls,
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmcd_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int TIMER_BITS  = TIMER_BITS_DEF;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

    // An index past the end of the register list; the unit must ignore it.
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_OF_RANGE = '1;

    // Time allowed for the whole run before it is declared hung (10 ms).
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // One expected result word, at the widths of the output channel.
    typedef struct packed {
        logic [PACK_BITS-1:0] pack_centivolts;
        logic [PACK_BITS-1:0] cell_centivolts;
        logic [CELL_BITS-1:0] cells_in_use;
        logic                 pack_present;
        logic                 alarm_active;
        logic                 alarm_started;
        logic                 alarm_stopped;
    } t_reading;

    // How the result side paces its ready line.
    typedef enum int {
        SINK_STEADY,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_pattern;

    logic i_clk;
    logic i_rst_n;

    bmcd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    bmcd_out_if out_if ();
    bmcd_cfg_if cfg_if ();

    battery_monitor_cell_detect_unit #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------

    // Result words predicted for accepted samples, oldest first.
    t_reading expected_readings[$];
    int       fail_count = 0;

    // Our own copy of the unit's registers, updated when a write is accepted.
    logic [EMPTY_BITS-1:0] cfg_empty_cv    = EMPTY_RESET;
    logic [CELL_BITS-1:0]  cfg_fixed_cells = '0;

    // Our own copy of the monitor state, at its reset values.
    bit                    pack_on     = 1'b0;
    longint unsigned       hold_us     = '0;
    logic [CELL_BITS-1:0]  found_cells = CELL_BITS'(1);
    logic [THR_BITS-1:0]   empty_limit = '0;
    bit                    alarm_on    = 1'b0;

    // Sender pacing: words left in the current burst, and a switch that turns
    // the gaps off so the sender keeps pushing against a stalled unit.
    int burst_left    = 0;
    bit sender_steady = 1'b0;

    // Set by a test to make the result side hold ready low for that many
    // cycles; the sink process counts it down.
    int sink_hold_cycles = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The fixed count wins whenever it is nonzero; otherwise the detected one.
    function automatic logic [CELL_BITS-1:0] cells_selected();
        return (cfg_fixed_cells != '0) ? cfg_fixed_cells : found_cells;
    endfunction

    // Advances the monitor state by one accepted sample and queues the result
    // word that the unit must produce for it.
    function automatic void predict_reading(input logic [SAMPLE_BITS-1:0]  raw,
                                            input logic [ELAPSED_BITS-1:0] el);
        t_reading             word;
        int unsigned          pack;
        longint unsigned      held;
        logic [CELL_BITS-1:0] cells;
        bit                   started;
        bit                   stopped;

        started = 1'b0;
        stopped = 1'b0;
        pack = (32'(raw) * FULL_SCALE_CV) >> SAMPLE_BITS;

        // The hold timer accumulates first and saturates at its full width.
        held = hold_us + 64'(el);
        hold_us = (held > TIMER_MAX) ? TIMER_MAX : held;

        if (!pack_on) begin
            if (pack < ATTACH_MIN_CV) begin
                hold_us = '0;
            end else if (hold_us > ATTACH_HOLD_US) begin
                if (cfg_fixed_cells == '0) begin
                    found_cells = CELL_BITS'((pack - CELL_OFFSET_CV) / CELL_SPAN_CV + 1);
                end
                empty_limit = THR_BITS'(32'(cells_selected()) * 32'(cfg_empty_cv));
                pack_on = 1'b1;
            end
        end else begin
            if (pack > DETACH_MAX_CV) begin
                hold_us = '0;
            end else if (hold_us > DETACH_HOLD_US) begin
                if (cfg_fixed_cells == '0) begin
                    found_cells = CELL_BITS'(1);
                end
                empty_limit = '0;
                pack_on = 1'b0;
            end
        end

        cells = cells_selected();

        if (alarm_on && (pack >= 32'(empty_limit) || pack < ALARM_FLOOR_CV)) begin
            alarm_on = 1'b0;
            stopped = 1'b1;
        end else if (!alarm_on && pack < 32'(empty_limit)) begin
            alarm_on = 1'b1;
            started = 1'b1;
        end

        word.pack_centivolts = PACK_BITS'(pack);
        word.cell_centivolts = PACK_BITS'(pack / ((cells == '0) ? 1 : 32'(cells)));
        word.cells_in_use    = cells;
        word.pack_present    = pack_on;
        word.alarm_active    = alarm_on;
        word.alarm_started   = started;
        word.alarm_stopped   = stopped;
        expected_readings.push_back(word);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input logic [31:0] got);
        if (got !== 32'(want)) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Every result word taken at a clock edge is matched against the oldest
    // prediction. A word with nothing waiting is a failure of its own.
    initial begin : reading_checker
        t_reading want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result word: pack_centivolts %0d",
                           out_if.pack_centivolts);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("pack_centivolts", 32'(want.pack_centivolts),
                                32'(out_if.pack_centivolts));
                    check_field("cell_centivolts", 32'(want.cell_centivolts),
                                32'(out_if.cell_centivolts));
                    check_field("cells_in_use", 32'(want.cells_in_use),
                                32'(out_if.cells_in_use));
                    check_field("pack_present", 32'(want.pack_present),
                                32'(out_if.pack_present));
                    check_field("alarm_active", 32'(want.alarm_active),
                                32'(out_if.alarm_active));
                    check_field("alarm_started", 32'(want.alarm_started),
                                32'(out_if.alarm_started));
                    check_field("alarm_stopped", 32'(want.alarm_stopped),
                                32'(out_if.alarm_stopped));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side pacing
    // ------------------------------------------------------------------------
    // The ready line follows a random pattern, picked anew when one runs out:
    // always ready, random stalls, or a fixed duty cycle. A hold-off request
    // from a test overrides the pattern until its count runs out.
    initial begin : result_sink
        int            pattern_left;
        int            tick;
        t_sink_pattern pattern;

        pattern_left = 0;
        tick = 0;
        pattern = SINK_STEADY;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (sink_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                if (pattern_left == 0) begin
                    pattern = t_sink_pattern'($urandom_range(0, 2));
                    pattern_left = $urandom_range(16, 160);
                end
                pattern_left--;
                case (pattern)
                    SINK_STEADY: begin
                        out_if.ready <= 1'b1;
                    end
                    SINK_RANDOM: begin
                        out_if.ready <= ($urandom_range(0, 2) != 0);
                    end
                    default: begin
                        // Ready at a fixed duty cycle set by the tick counter.
                        out_if.ready <= ((tick % 11) < 4);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one sample word and waits until the unit takes it. The sender
    // keeps valid high through a burst and drops it only for a gap, so valid
    // never sees two assignments in one time step.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0]  raw,
                               input logic [ELAPSED_BITS-1:0] el);
        int gap;
        in_if.valid      <= 1'b1;
        in_if.raw_sample <= raw;
        in_if.elapsed_us <= el;
        do @(posedge i_clk); while (!in_if.ready);
        predict_reading(raw, el);
        if (!sender_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 12);
                // Mostly short bursts, now and then a long gapless stretch.
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 6);
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Writes one register. The last write of a group drops valid.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] wdata,
                             input bit                       last);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= wdata;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_EMPTY_CELL:  cfg_empty_cv    = wdata[EMPTY_BITS-1:0];
            REG_FIXED_COUNT: cfg_fixed_cells = wdata[CELL_BITS-1:0];
            default: begin
                // Indexes past the register list leave everything as it is.
            end
        endcase
        if (last) begin
            cfg_if.valid <= 1'b0;
        end
    endtask

    // Stops offering samples and waits until every predicted word has come
    // back. Every sample yields exactly one word, so the unit is idle then.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Full-scale and zero samples with the largest and smallest time steps.
    // The attach at full scale leaves the timer high, so the next low sample
    // detaches at once: the timer is not cleared on a mode change.
    task automatic test_scaling_extremes();
        send_sample(12'd0, 20'd0);
        send_sample(12'hFFF, 20'hFFFFF);
        send_sample(12'd0, 20'd0);
        wait_idle();
    endtask

    // Both hold times right at their limits, and the attach threshold right
    // at 2.50 V. Attaching at 2.50 V with one cell starts the alarm.
    task automatic test_hold_limits();
        send_sample(12'd282, 20'd1000000);   // 2.49 V clears the timer
        send_sample(12'd283, 20'd1000000);   // exactly 1 s: not yet
        send_sample(12'd283, 20'd1);         // just over 1 s: attach
        send_sample(12'd171, 20'd0);         // 1.51 V clears the timer
        send_sample(12'd170, 20'd500000);    // 1.50 V for exactly 0.5 s
        send_sample(12'd170, 20'd1);         // just over: detach
        wait_idle();
    endtask

    // Cell detection on both sides of the one/two cell boundary.
    task automatic test_cell_detection();
        send_sample(12'd504, 20'hFFFFF);     // 4.46 V: two cells
        send_sample(12'd0, 20'hFFFFF);
        send_sample(12'd503, 20'hFFFFF);     // 4.45 V: one cell
        send_sample(12'd0, 20'hFFFFF);
        wait_idle();
    endtask

    // Alarm start and stop around the empty threshold, and the floor below
    // 0.50 V that switches a running alarm off.
    task automatic test_alarm_edges();
        send_sample(12'd452, 20'hFFFFF);     // attach at 4.00 V, threshold 3.50 V
        send_sample(12'd395, 20'd0);         // exactly at threshold: quiet
        send_sample(12'd394, 20'd0);         // just below: alarm starts
        send_sample(12'd395, 20'd0);         // back at threshold: alarm stops
        send_sample(12'd56, 20'd0);          // 0.49 V, alarm off: starts
        send_sample(12'd56, 20'd0);          // under the floor: stops
        send_sample(12'd56, 20'd0);          // starts again
        send_sample(12'd0, 20'hFFFFF);       // detach, threshold drops to zero
        wait_idle();
    endtask

    // Register writes: upper data bits are masked, an index past the list is
    // ignored, the largest empty setting is used as is, and a fixed count
    // changed while attached moves the cell count at once but leaves the
    // threshold alone until the next attach.
    task automatic test_register_writes();
        write_reg(REG_EMPTY_CELL, 16'hFFFF, 1'b0);
        write_reg(REG_OUT_OF_RANGE, 16'h1234, 1'b0);
        write_reg(REG_FIXED_COUNT, 16'hFFFF, 1'b1);
        send_sample(12'hFFF, 20'hFFFFF);     // attach, 15 cells, alarm starts
        wait_idle();
        write_reg(REG_FIXED_COUNT, 16'hFFF1, 1'b1);
        send_sample(12'hFFF, 20'd0);
        wait_idle();
        write_reg(REG_FIXED_COUNT, 16'hFFF0, 1'b0);
        write_reg(REG_EMPTY_CELL, 16'h0000, 1'b1);
        send_sample(12'd0, 20'hFFFFF);       // detach
        wait_idle();
    endtask

    // Random words shaped into the sequences that move the state machine:
    // attach runs, stretches near the empty threshold, detach runs, and some
    // plain noise over the full range of both fields.
    task automatic run_random_words(input int n_words);
        int                      sent;
        int                      mix;
        int                      len;
        int                      k;
        int                      target;
        int                      rv;
        logic [SAMPLE_BITS-1:0]  raw;
        logic [ELAPSED_BITS-1:0] el;

        sent = 0;
        while (sent < n_words) begin
            mix = $urandom_range(0, 99);
            len = $urandom_range(2, 6);
            for (k = 0; k < len && sent < n_words; k++) begin
                if (mix < 35) begin
                    raw = SAMPLE_BITS'($urandom_range(283, (1 << SAMPLE_BITS) - 1));
                    el  = ELAPSED_BITS'($urandom_range(200000, (1 << ELAPSED_BITS) - 1));
                end else if (mix < 70) begin
                    if ($urandom_range(0, 7) == 0) begin
                        // Near and under the alarm floor.
                        raw = SAMPLE_BITS'($urandom_range(0, 60));
                    end else begin
                        target = (pack_on && empty_limit != '0) ? int'(empty_limit)
                                                                : $urandom_range(0, 600);
                        rv = target * (1 << SAMPLE_BITS) / FULL_SCALE_CV
                             + int'($urandom_range(0, 40)) - 20;
                        if (rv < 0) rv = 0;
                        if (rv > (1 << SAMPLE_BITS) - 1) rv = (1 << SAMPLE_BITS) - 1;
                        raw = SAMPLE_BITS'(rv);
                    end
                    el = ELAPSED_BITS'($urandom_range(0, 5000));
                end else if (mix < 88) begin
                    raw = SAMPLE_BITS'($urandom_range(0, 175));
                    el  = ELAPSED_BITS'($urandom_range(50000, 400000));
                end else begin
                    raw = SAMPLE_BITS'($urandom);
                    el  = ELAPSED_BITS'($urandom);
                end
                send_sample(raw, el);
                sent++;
            end
        end
    endtask

    // Several register settings, the extremes among them, each followed by a
    // batch of random words. State carries over from one setting to the next.
    task automatic test_random_settings();
        int                    empty_list[8] = '{350, 0, 500, 511, 137, 500, 0, -1};
        int                    fixed_list[8] = '{0, 0, 0, 15, 1, 3, 15, -1};
        int                    p;
        logic [EMPTY_BITS-1:0] empty_cv;
        logic [CELL_BITS-1:0]  fixed_cells;

        for (p = 0; p < 8; p++) begin
            wait_idle();
            // A negative entry means a random setting for that phase.
            empty_cv    = (empty_list[p] < 0) ? EMPTY_BITS'($urandom)
                                              : EMPTY_BITS'(empty_list[p]);
            fixed_cells = (fixed_list[p] < 0) ? CELL_BITS'($urandom)
                                              : CELL_BITS'(fixed_list[p]);
            write_reg(REG_EMPTY_CELL, CFG_DATA_BITS'(empty_cv), 1'b0);
            write_reg(REG_FIXED_COUNT, CFG_DATA_BITS'(fixed_cells), 1'b1);
            run_random_words(50);
        end
        wait_idle();
    endtask

    // The result side holds off for a long stretch while the sender keeps
    // offering words without gaps. The unit fills its output register and its
    // pipeline, then must stall the input until the hold-off ends.
    task automatic test_output_backpressure();
        int k;
        wait_idle();
        write_reg(REG_EMPTY_CELL, CFG_DATA_BITS'(EMPTY_RESET), 1'b0);
        write_reg(REG_FIXED_COUNT, '0, 1'b1);
        sink_hold_cycles = 400;
        sender_steady = 1'b1;
        for (k = 0; k < 16; k++) begin
            send_sample(SAMPLE_BITS'($urandom), ELAPSED_BITS'($urandom));
        end
        sender_steady = 1'b0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.raw_sample <= '0;
        in_if.elapsed_us <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_scaling_extremes();
        test_hold_limits();
        test_cell_detection();
        test_alarm_edges();
        test_register_writes();
        test_random_settings();
        test_output_backpressure();

        // Leave room for any stray word after the last expected one.
        wait_idle();
        repeat (60) @(posedge i_clk);

        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bmcd_pkg.sv
rtl/core/bmcd_if.sv
rtl/core/bmcd_ctrl.sv
rtl/core/bmcd_dp.sv
rtl/core/battery_monitor_cell_detect_unit.sv
dv/tb_top.sv
